### design/alu8_pkg.sv
// Shared types and operation codes for the eight-bit ALU.
// No dependencies; imported by the top level, the core and the checker.
package alu8_pkg;

  typedef enum logic [3:0] {
    OP_OR   = 4'd0,
    OP_AND  = 4'd1,
    OP_XOR  = 4'd2,
    OP_ADD  = 4'd3,
    OP_SUB  = 4'd4,
    OP_CMP  = 4'd5,
    OP_INC  = 4'd6,
    OP_DEC  = 4'd7,
    OP_ASL  = 4'd8,
    OP_LSR  = 4'd9,
    OP_ROL  = 4'd10,
    OP_ROR  = 4'd11,
    OP_BIT  = 4'd12,
    OP_LOAD = 4'd13
  } alu8_op_t;

  // Status byte bit positions
  localparam int unsigned FLAG_C = 0;
  localparam int unsigned FLAG_Z = 1;
  localparam int unsigned FLAG_V = 6;
  localparam int unsigned FLAG_N = 7;

  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 24;

  typedef struct packed {
    logic [7:0] status_in;
    logic [7:0] operand_b;
    logic [7:0] operand_a;
    logic [3:0] cmd;
  } alu8_in_t;

  typedef struct packed {
    logic       write_back;
    logic [7:0] status_out;
    logic [7:0] result;
  } alu8_out_t;

endpackage

### design/eight_bit_alu_with_status_flags.sv
// Eight-bit ALU with N, Z, C and V status flags, stream in and stream out.
// Path: input register, then the single combinational pass, then result
// register; the result transfer follows both registers. Throughput: one
// operation per cycle while the sink is ready; a stalled result holds the
// result register and, once that stage is full, the input register.
// Reset: synchronous, active high; empties both stages, no result pending.
module eight_bit_alu_with_status_flags
  import alu8_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // bits from 0 up: cmd[3:0], operand_a[11:4], operand_b[19:12],
  // status_in[27:20], zero pad[31:28]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // bits from 0 up: result[7:0], status_out[15:8], write_back[16],
  // zero pad[23:17]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int unsigned IN_W  = $bits(alu8_in_t);
  localparam int unsigned OUT_W = $bits(alu8_out_t);

  alu8_in_t  in_word;
  alu8_in_t  op_word;
  alu8_out_t res_word;
  alu8_out_t out_word;
  logic      op_valid;
  logic      op_ready;

  // Drop the pad bits of the incoming transfer
  assign in_word = alu8_in_t'(s_axis_tdata[IN_W-1:0]);

  // Input register: holds the operation while the result stage is full
  alu8_stage #(.WIDTH(IN_W)) u_in_stage (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (in_word),
    .out_valid (op_valid),
    .out_ready (op_ready),
    .out_data  (op_word)
  );

  // One short pass of operation and flag logic
  alu8_core u_core (
    .op_in  (op_word),
    .op_out (res_word)
  );

  // Result register: a finished result waits here while a new item enters
  alu8_stage #(.WIDTH(OUT_W)) u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (op_valid),
    .in_ready  (op_ready),
    .in_data   (res_word),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_word)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W - OUT_W){1'b0}}, out_word};

endmodule

### design/alu8_stage.sv
// One register stage with valid/ready flow control for the eight-bit ALU.
// Depends on nothing but its WIDTH parameter.
module alu8_stage #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic             valid;
  logic [WIDTH-1:0] data;

  // Take a new word when empty or when the held word leaves this cycle
  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= in_data;
    end
  end

endmodule

### design/alu8_core.sv
// Combinational operation and flag logic of the eight-bit ALU.
// Depends on alu8_pkg for the operand/result structs and operation codes.
module alu8_core
  import alu8_pkg::*;
(
  input  alu8_in_t  op_in,
  output alu8_out_t op_out
);

  logic [7:0] a;
  logic [7:0] b;
  logic [7:0] st;
  logic       cin;
  logic [7:0] addend;
  logic [8:0] sum;
  logic [8:0] diff;
  logic [7:0] r;
  logic       set_nz;

  assign a   = op_in.operand_a;
  assign b   = op_in.operand_b;
  assign cin = op_in.status_in[FLAG_C];

  // Subtract adds the inverted operand plus carry
  assign addend = (alu8_op_t'(op_in.cmd) == OP_SUB) ? ~b : b;
  assign sum    = {1'b0, a} + {1'b0, addend} + {8'd0, cin};
  assign diff   = {1'b0, a} - {1'b0, b};

  always_comb begin
    st     = op_in.status_in;
    r      = a;
    set_nz = 1'b1;
    op_out.write_back = 1'b1;
    case (alu8_op_t'(op_in.cmd))
      OP_OR:   r = a | b;
      OP_AND:  r = a & b;
      OP_XOR:  r = a ^ b;
      OP_ADD, OP_SUB: begin
        r = sum[7:0];
        st[FLAG_C] = sum[8];
        st[FLAG_V] = ~(a[7] ^ addend[7]) & (a[7] ^ sum[7]);
      end
      OP_CMP: begin
        r = diff[7:0];
        st[FLAG_C] = ~diff[8];
        op_out.write_back = 1'b0;
      end
      OP_INC:  r = b + 8'd1;
      OP_DEC:  r = b - 8'd1;
      OP_ASL: begin
        r = {b[6:0], 1'b0};
        st[FLAG_C] = b[7];
      end
      OP_LSR: begin
        r = {1'b0, b[7:1]};
        st[FLAG_C] = b[0];
      end
      OP_ROL: begin
        r = {b[6:0], cin};
        st[FLAG_C] = b[7];
      end
      OP_ROR: begin
        r = {cin, b[7:1]};
        st[FLAG_C] = b[0];
      end
      OP_BIT: begin
        r = a & b;
        set_nz = 1'b0;
        st[FLAG_N] = b[7];
        st[FLAG_V] = b[6];
        st[FLAG_Z] = (r == 8'd0);
        op_out.write_back = 1'b0;
      end
      OP_LOAD: r = b;
      default: begin
        r = a;
        set_nz = 1'b0;
        op_out.write_back = 1'b0;
      end
    endcase
    if (set_nz) begin
      st[FLAG_N] = r[7];
      st[FLAG_Z] = (r == 8'd0);
    end
    op_out.result     = r;
    op_out.status_out = st;
  end

endmodule

### design/alu8_checker.sv
// Port-level checks for the eight-bit ALU, bound to the top level.
// Depends on alu8_pkg for the stream widths.
module alu8_checker
  import alu8_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // No result pending right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // An empty output side never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // With the sink ready, an accepted operation reaches the result register and shows as valid
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("result missing after two cycles");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind eight_bit_alu_with_status_flags alu8_checker u_alu8_checker (.*);

### tb/tb_top.sv
// Self-checking bench for the eight-bit ALU with N, Z, C and V flags.
// Streams operations through the ALU and checks every result against a local predictor.
// Depends on alu8_pkg and eight_bit_alu_with_status_flags.
module tb_top;
  import alu8_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Codes 14 and 15 have no operation: the ALU passes operand_a and the status through
  localparam logic [3:0] CMD_UNUSED_E = 4'd14;
  localparam logic [3:0] CMD_UNUSED_F = 4'd15;

  localparam int unsigned RANDOM_OPS_PER_PHASE = 425;
  localparam int unsigned HOLDOFF_CYCLES       = 300;
  localparam int unsigned HOLDOFF_AT_RESULT    = 100;
  localparam int unsigned WATCHDOG_LIMIT       = 2000;
  localparam int unsigned MAX_REPORTS          = 10;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // bits from 0 up: cmd[3:0], operand_a[11:4], operand_b[19:12], status_in[27:20], pad[31:28]
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // bits from 0 up: result[7:0], status_out[15:8], write_back[16], pad[23:17]
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // Operations waiting to be offered, and results the ALU still owes
  alu8_in_t    pending_ops[$];
  alu8_out_t   expected_results[$];
  alu8_in_t    held_op;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned ops_sent        = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches      = 0;
  int unsigned holdoff_left    = 0;
  bit          holdoff_done    = 1'b0;
  int unsigned quiet_cycles    = 0;
  int unsigned code_hits[16];

  eight_bit_alu_with_status_flags u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Compute the result, the updated status byte and the write-back mark of one operation
  function automatic alu8_out_t predict_alu_result(alu8_in_t op);
    alu8_out_t  res;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] r;
    logic [7:0] st;
    logic [7:0] addend;
    logic [8:0] sum;
    logic       cin;
    logic       wb;
    logic       upd_nz;
    a      = op.operand_a;
    b      = op.operand_b;
    st     = op.status_in;
    cin    = st[FLAG_C];
    r      = a;
    wb     = 1'b1;
    upd_nz = 1'b1;
    case (op.cmd)
      OP_OR:  r = a | b;
      OP_AND: r = a & b;
      OP_XOR: r = a ^ b;
      OP_ADD, OP_SUB: begin
        // subtract is add of the inverted operand, carry in acting as not-borrow
        addend     = (op.cmd == OP_SUB) ? ~b : b;
        sum        = {1'b0, a} + {1'b0, addend} + {8'd0, cin};
        r          = sum[7:0];
        st[FLAG_C] = sum[8];
        st[FLAG_V] = ~(a[7] ^ addend[7]) & (a[7] ^ r[7]);
      end
      OP_CMP: begin
        r          = a - b;
        st[FLAG_C] = (a >= b);
        wb         = 1'b0;
      end
      OP_INC: r = b + 8'd1;
      OP_DEC: r = b - 8'd1;
      OP_ASL: begin
        r          = {b[6:0], 1'b0};
        st[FLAG_C] = b[7];
      end
      OP_LSR: begin
        r          = {1'b0, b[7:1]};
        st[FLAG_C] = b[0];
      end
      OP_ROL: begin
        r          = {b[6:0], cin};
        st[FLAG_C] = b[7];
      end
      OP_ROR: begin
        r          = {cin, b[7:1]};
        st[FLAG_C] = b[0];
      end
      OP_BIT: begin
        // N and V come from the memory operand, Z from the masked value
        r          = a & b;
        st[FLAG_N] = b[7];
        st[FLAG_V] = b[6];
        st[FLAG_Z] = (r == 8'd0);
        wb         = 1'b0;
        upd_nz     = 1'b0;
      end
      OP_LOAD: r = b;
      default: begin
        wb     = 1'b0;
        upd_nz = 1'b0;
      end
    endcase
    if (upd_nz) begin
      st[FLAG_N] = r[7];
      st[FLAG_Z] = (r == 8'd0);
    end
    res.result     = r;
    res.status_out = st;
    res.write_back = wb;
    return res;
  endfunction

  // Bias toward the corners of the byte range
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      default: return 8'($urandom());
    endcase
  endfunction

  task automatic queue_op(logic [3:0] code, logic [7:0] a, logic [7:0] b, logic [7:0] st);
    alu8_in_t op;
    op.cmd       = code;
    op.operand_a = a;
    op.operand_b = b;
    op.status_in = st;
    pending_ops.insert(pending_ops.size(), op);
  endtask

  task automatic queue_random_ops(int unsigned count);
    repeat (count) begin
      queue_op(4'($urandom_range(15)), pick_byte(), pick_byte(), pick_byte());
    end
  endtask

  // Hold until every queued operation has been offered and taken
  task automatic drain_pending();
    while (pending_ops.size() != 0 || s_axis_tvalid) @(negedge clk);
  endtask

  task automatic flag_error(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("mismatch: %s", msg);
  endtask

  // Driver: offer the next operation whenever the slot is free or its transfer happens now;
  // predict each operation at the edge where it is accepted
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        expected_results.insert(expected_results.size(), predict_alu_result(held_op));
        code_hits[held_op.cmd]++;
        ops_sent++;
      end
      if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        held_op = pending_ops.pop_front();
        s_axis_tdata  <= {4'b0000, held_op};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: check each result transfer against the oldest prediction, then decide
  // the next cycle's ready, including one long hold-off to back the pipe up
  always @(posedge clk) begin
    alu8_out_t got;
    alu8_out_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = alu8_out_t'(m_axis_tdata[16:0]);
        results_checked++;
        if (expected_results.size() == 0) begin
          flag_error($sformatf("result %0d arrived with none outstanding: res=%02h st=%02h wb=%0b",
                               results_checked, got.result, got.status_out, got.write_back));
        end else begin
          want = expected_results.pop_front();
          if (got.result !== want.result || got.status_out !== want.status_out ||
              got.write_back !== want.write_back) begin
            flag_error($sformatf(
              "result %0d: expected res=%02h st=%02h wb=%0b, got res=%02h st=%02h wb=%0b",
              results_checked, want.result, want.status_out, want.write_back,
              got.result, got.status_out, got.write_back));
          end
        end
        if (!holdoff_done && results_checked == HOLDOFF_AT_RESULT) begin
          holdoff_left = HOLDOFF_CYCLES;
          holdoff_done = 1'b1;
        end
      end
      if (holdoff_left != 0) begin
        holdoff_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: end the run if no transfer happens on either side for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, expected_results.size());
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned codes_covered;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed corners, no idling on either side
    queue_op(OP_OR,   8'h00, 8'h00, 8'h00);   // zero result sets Z
    queue_op(OP_AND,  8'hFF, 8'hFF, 8'hFF);
    queue_op(OP_XOR,  8'hAA, 8'h55, 8'h00);
    queue_op(OP_ADD,  8'h7F, 8'h01, 8'h00);   // signed overflow into N
    queue_op(OP_ADD,  8'hFF, 8'h01, 8'h01);   // carry out with carry in
    queue_op(OP_ADD,  8'h80, 8'h80, 8'h00);   // overflow, carry and zero at once
    queue_op(OP_SUB,  8'h00, 8'h01, 8'h01);   // borrow out
    queue_op(OP_SUB,  8'h80, 8'h01, 8'h01);   // signed overflow on subtract
    queue_op(OP_SUB,  8'h50, 8'h50, 8'h00);   // borrow in from clear carry
    queue_op(OP_CMP,  8'h40, 8'h40, 8'h00);   // equal: C and Z set
    queue_op(OP_CMP,  8'h00, 8'hFF, 8'hFF);   // a below b: C clear
    queue_op(OP_CMP,  8'hFF, 8'h00, 8'h00);
    queue_op(OP_INC,  8'h00, 8'hFF, 8'h00);   // wrap to zero
    queue_op(OP_DEC,  8'h00, 8'h00, 8'h00);   // wrap to all ones
    queue_op(OP_ASL,  8'h00, 8'h80, 8'h00);
    queue_op(OP_LSR,  8'h00, 8'h01, 8'h00);
    queue_op(OP_ROL,  8'h00, 8'h80, 8'h01);   // old carry rotates into bit 0
    queue_op(OP_ROR,  8'h00, 8'h01, 8'h01);   // old carry rotates into bit 7
    queue_op(OP_BIT,  8'h0F, 8'hF0, 8'h00);   // no common bits: Z, with N and V from b
    queue_op(OP_BIT,  8'hFF, 8'h3F, 8'hFF);
    queue_op(OP_LOAD, 8'hFF, 8'h00, 8'hFF);
    queue_op(OP_LOAD, 8'h00, 8'h80, 8'h00);
    queue_op(CMD_UNUSED_E, 8'hA5, 8'h5A, 8'h00);
    queue_op(CMD_UNUSED_F, 8'h5A, 8'hA5, 8'hFF);
    drain_pending();

    // Random phases: free flowing (with the long receiver hold-off), sender gaps,
    // receiver stalls, then both
    queue_random_ops(RANDOM_OPS_PER_PHASE);
    drain_pending();
    send_idle_pct = 47;
    queue_random_ops(RANDOM_OPS_PER_PHASE);
    drain_pending();
    send_idle_pct  = 0;
    recv_stall_pct = 47;
    queue_random_ops(RANDOM_OPS_PER_PHASE);
    drain_pending();
    send_idle_pct  = 16;
    recv_stall_pct = 16;
    queue_random_ops(RANDOM_OPS_PER_PHASE);
    drain_pending();

    // Wait out every outstanding result, then allow the pipeline latency to settle
    while (expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);

    codes_covered = 0;
    foreach (code_hits[i]) if (code_hits[i] != 0) codes_covered++;
    $display("run: %0d operations in, %0d results checked, %0d of 16 codes hit, %0d mismatches",
             ops_sent, results_checked, codes_covered, mismatches);
    $display("run: idle mixes none, sender 47%%, receiver 47%%, both 16%%; one %0d-cycle hold-off",
             HOLDOFF_CYCLES);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
